[src/lle_pkg.sv]
// Shared types and constants for the linked line editor.
// Holds the item and result payloads and the controller/datapath command and status structs.
// No dependencies.
package lle_pkg;

	localparam int LLE_MAX_NODES = 64;

	localparam int ID_W      = 7;
	localparam int CNT_W     = 16;
	localparam int SUM_W     = 32;
	localparam int OP_W      = 2;
	localparam int CFG_IDX_W = 1;

	localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
	localparam logic [OP_W-1:0] OP_MOVE    = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE  = 2'd2;
	localparam logic [OP_W-1:0] OP_RESTART = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_NODE = 1'b1;

	localparam logic [ID_W-1:0] NODE_COUNT_RST = 7'd64;
	localparam logic [ID_W-1:0] FIRST_NODE_RST = 7'd1;

	// node_c value that selects "before" for insert and "backward" for remove.
	localparam logic [ID_W-1:0] DIR_BACK = 7'd1;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [ID_W-1:0]  node_a;
		logic [CNT_W-1:0] node_b;
		logic [ID_W-1:0]  node_c;
	} item_t;

	typedef struct packed {
		logic [ID_W-1:0]  removed_node;
		logic             node_valid;
		logic [SUM_W-1:0] shortfall_total;
		logic             last;
	} result_t;

	// Link table read selection.
	typedef enum logic [2:0] {
		RD_NONE,
		RD_B,
		RD_AB,
		RD_C,
		RD_A,
		RD_CUR
	} rd_sel_t;

	// Link write (join x -> y) selection.
	typedef enum logic [3:0] {
		JN_NONE,
		JN_CLEAR,
		JN_HEAD,
		JN_TAIL,
		JN_PREV_A,
		JN_A_B,
		JN_A_NEXT,
		JN_B_A,
		JN_PREV_NEXT,
		JN_B_C,
		JN_LO_HI
	} join_sel_t;

	typedef struct packed {
		logic      load;
		rd_sel_t   rd;
		join_sel_t wr;
		logic      walk_count;
		logic      sum_update;
		logic      sum_clear;
		logic      walk_emit;
		logic      emit_empty;
	} cmd_t;

	typedef struct packed {
		logic a_ok;
		logic b_ok;
		logic c_ok;
		logic c_back;
		logic cur_ok;
		logic k_zero;
		logic j_last;
		logic clr_done;
		logic out_free;
	} status_t;

endpackage

[src/lle_ctrl.sv]
// Controller state machine of the linked line editor.
// Sequences link table reads, joins, remove walks and result emission.
// Depends on lle_pkg.
module lle_ctrl
	import lle_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  logic [OP_W-1:0] operation,
	output logic            item_stall,
	input  status_t         status,
	output cmd_t            cmd
);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLR,
		ST_RST_HEAD,
		ST_RST_TAIL,
		ST_INS_RD,
		ST_INS_J1,
		ST_INS_J2,
		ST_MV_RD,
		ST_MV_J1,
		ST_MV_RD2,
		ST_MV_J2,
		ST_MV_J3,
		ST_RM_RD,
		ST_RM_WALK,
		ST_RM_SUM,
		ST_RM_EMIT,
		ST_RM_EMPTY,
		ST_RM_JOIN
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign item_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd       = '0;
		cmd.rd    = RD_NONE;
		cmd.wr    = JN_NONE;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					unique case (operation)
						OP_INSERT:  state_nxt = ST_INS_RD;
						OP_MOVE:    state_nxt = ST_MV_RD;
						OP_REMOVE:  state_nxt = ST_RM_RD;
						OP_RESTART: state_nxt = ST_CLR;
						default:    state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_CLR: begin
				cmd.wr = JN_CLEAR;
				if (status.clr_done) begin
					state_nxt = ST_RST_HEAD;
				end
			end
			ST_RST_HEAD: begin
				cmd.wr    = JN_HEAD;
				state_nxt = ST_RST_TAIL;
			end
			ST_RST_TAIL: begin
				cmd.wr        = JN_TAIL;
				cmd.sum_clear = 1'b1;
				state_nxt     = ST_IDLE;
			end
			ST_INS_RD: begin
				cmd.rd    = RD_B;
				state_nxt = (status.a_ok && status.b_ok) ? ST_INS_J1 : ST_IDLE;
			end
			ST_INS_J1: begin
				cmd.wr    = status.c_back ? JN_PREV_A : JN_A_NEXT;
				state_nxt = ST_INS_J2;
			end
			ST_INS_J2: begin
				cmd.wr    = status.c_back ? JN_A_B : JN_B_A;
				state_nxt = ST_IDLE;
			end
			ST_MV_RD: begin
				cmd.rd    = RD_AB;
				state_nxt = (status.a_ok && status.b_ok && status.c_ok) ? ST_MV_J1 : ST_IDLE;
			end
			ST_MV_J1: begin
				cmd.wr    = JN_PREV_NEXT;
				state_nxt = ST_MV_RD2;
			end
			ST_MV_RD2: begin
				// prev of the target is read only after the first join has landed.
				cmd.rd    = RD_C;
				state_nxt = ST_MV_J2;
			end
			ST_MV_J2: begin
				cmd.wr    = JN_PREV_A;
				state_nxt = ST_MV_J3;
			end
			ST_MV_J3: begin
				cmd.wr    = JN_B_C;
				state_nxt = ST_IDLE;
			end
			ST_RM_RD: begin
				cmd.rd    = RD_A;
				state_nxt = ST_RM_WALK;
			end
			ST_RM_WALK: begin
				cmd.rd         = RD_CUR;
				cmd.walk_count = 1'b1;
				if (!status.cur_ok) begin
					state_nxt = ST_RM_SUM;
				end
			end
			ST_RM_SUM: begin
				cmd.sum_update = 1'b1;
				state_nxt      = status.k_zero ? ST_RM_EMPTY : ST_RM_EMIT;
			end
			ST_RM_EMIT: begin
				if (status.out_free) begin
					cmd.rd        = RD_CUR;
					cmd.walk_emit = 1'b1;
					if (status.j_last) begin
						state_nxt = ST_RM_JOIN;
					end
				end
			end
			ST_RM_EMPTY: begin
				if (status.out_free) begin
					cmd.emit_empty = 1'b1;
					state_nxt      = ST_IDLE;
				end
			end
			ST_RM_JOIN: begin
				cmd.wr    = JN_LO_HI;
				state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

[src/lle_datapath.sv]
// Datapath of the linked line editor: link tables, walk counters, shortfall sum,
// configuration registers and the result register.
// Depends on lle_pkg.
module lle_datapath
	import lle_pkg::*;
#(
	parameter int MAX_NODES = LLE_MAX_NODES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  item_t                item,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ID_W-1:0]      cfg_data,
	input  logic                 result_stall,
	input  cmd_t                 cmd,
	output status_t              status,
	output result_t              result,
	output logic                 result_valid
);

	localparam int DEPTH = MAX_NODES + 3;
	localparam int AW    = $clog2(DEPTH);
	localparam int KW    = $clog2(MAX_NODES + 1);

	localparam logic [ID_W-1:0] MAX_ID   = ID_W'(MAX_NODES);
	localparam logic [ID_W-1:0] DEPTH_ID = ID_W'(DEPTH);
	localparam logic [AW-1:0]   CLR_LAST = AW'(DEPTH - 1);
	localparam logic [KW-1:0]   K_MAX    = KW'(MAX_NODES);

	function automatic logic is_node(input logic [ID_W-1:0] id, input logic [ID_W-1:0] n);
		return (id != '0) && (id <= n);
	endfunction

	logic [ID_W-1:0] next_link_q [DEPTH];
	logic [ID_W-1:0] prev_link_q [DEPTH];
	logic [ID_W-1:0] rd_next_q;
	logic [ID_W-1:0] rd_prev_q;

	logic [ID_W-1:0]  node_count_q;
	logic [ID_W-1:0]  first_node_q;
	logic [ID_W-1:0]  n_q;
	logic [ID_W-1:0]  f_q;
	logic [ID_W-1:0]  a_q;
	logic [CNT_W-1:0] b_q;
	logic [ID_W-1:0]  c_q;
	logic [AW-1:0]    clr_idx_q;
	logic             first_q;
	logic [CNT_W-1:0] cnt_q;
	logic [KW-1:0]    k_q;
	logic [KW-1:0]    j_q;
	logic [ID_W-1:0]  end_q;
	logic [ID_W-1:0]  other_q;
	logic [SUM_W-1:0] sum_q;
	result_t          res_q;
	logic             res_valid_q;

	logic [ID_W-1:0] n_new;
	logic [ID_W-1:0] f_new;
	logic            back;
	logic [ID_W-1:0] b_id;
	logic [ID_W-1:0] cur;
	logic [ID_W-1:0] lo;
	logic [ID_W-1:0] hi;
	logic            j_last;
	logic            out_free;
	logic [SUM_W:0]  sum_add;

	logic [ID_W-1:0] nr_id;
	logic [ID_W-1:0] pr_id;
	logic            nr_en;
	logic            pr_en;
	logic [ID_W-1:0] jx;
	logic [ID_W-1:0] jy;
	logic            nw_en;
	logic            pw_en;
	logic [AW-1:0]   nw_addr;
	logic [AW-1:0]   pw_addr;
	logic [ID_W-1:0] nw_data;
	logic [ID_W-1:0] pw_data;

	always_comb begin
		if (node_count_q == '0) begin
			n_new = ID_W'(1);
		end else if (node_count_q > MAX_ID) begin
			n_new = MAX_ID;
		end else begin
			n_new = node_count_q;
		end
		if (first_node_q == '0) begin
			f_new = ID_W'(1);
		end else if (first_node_q > n_new) begin
			f_new = n_new;
		end else begin
			f_new = first_node_q;
		end
	end

	assign back     = (c_q == DIR_BACK);
	assign b_id     = b_q[ID_W-1:0];
	assign cur      = first_q ? a_q : (back ? rd_prev_q : rd_next_q);
	assign lo       = back ? end_q : other_q;
	assign hi       = back ? other_q : end_q;
	assign j_last   = ((KW + 1)'(j_q) + (KW + 1)'(1)) == (KW + 1)'(k_q);
	assign out_free = !res_valid_q || !result_stall;
	assign sum_add  = (SUM_W + 1)'(sum_q) + (SUM_W + 1)'(cnt_q);

	assign status.a_ok     = is_node(a_q, n_q);
	assign status.b_ok     = (b_q != '0) && (b_q <= CNT_W'(n_q));
	assign status.c_ok     = is_node(c_q, n_q);
	assign status.c_back   = back;
	assign status.cur_ok   = is_node(cur, n_q) && (cnt_q != '0) && (k_q != K_MAX);
	assign status.k_zero   = (k_q == '0);
	assign status.j_last   = j_last;
	assign status.clr_done = (clr_idx_q == CLR_LAST);
	assign status.out_free = out_free;

	assign result       = res_q;
	assign result_valid = res_valid_q;

	// Read address selection; each table has its own read port.
	always_comb begin
		nr_id = '0;
		pr_id = '0;
		nr_en = 1'b0;
		pr_en = 1'b0;
		unique case (cmd.rd)
			RD_NONE: begin
			end
			RD_B: begin
				nr_id = b_id;
				pr_id = b_id;
				nr_en = 1'b1;
				pr_en = 1'b1;
			end
			RD_AB: begin
				nr_id = b_id;
				pr_id = a_q;
				nr_en = 1'b1;
				pr_en = 1'b1;
			end
			RD_C: begin
				pr_id = c_q;
				pr_en = 1'b1;
			end
			RD_A: begin
				nr_id = a_q;
				pr_id = a_q;
				nr_en = 1'b1;
				pr_en = 1'b1;
			end
			RD_CUR: begin
				nr_id = cur;
				pr_id = cur;
				nr_en = 1'b1;
				pr_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// A join x -> y writes next[x] = y and prev[y] = x in the same cycle.
	always_comb begin
		jx = '0;
		jy = '0;
		unique case (cmd.wr)
			JN_NONE:      begin end
			JN_CLEAR:     begin end
			JN_HEAD:      begin jx = n_q + ID_W'(1); jy = f_q;               end
			JN_TAIL:      begin jx = f_q;            jy = n_q + ID_W'(2);    end
			JN_PREV_A:    begin jx = rd_prev_q;      jy = a_q;               end
			JN_A_B:       begin jx = a_q;            jy = b_id;              end
			JN_A_NEXT:    begin jx = a_q;            jy = rd_next_q;         end
			JN_B_A:       begin jx = b_id;           jy = a_q;               end
			JN_PREV_NEXT: begin jx = rd_prev_q;      jy = rd_next_q;         end
			JN_B_C:       begin jx = b_id;           jy = c_q;               end
			JN_LO_HI:     begin jx = lo;             jy = hi;                end
			default:      begin end
		endcase
		if (cmd.wr == JN_CLEAR) begin
			nw_en   = 1'b1;
			pw_en   = 1'b1;
			nw_addr = clr_idx_q;
			pw_addr = clr_idx_q;
			nw_data = '0;
			pw_data = '0;
		end else begin
			nw_en   = (cmd.wr != JN_NONE) && (jx < DEPTH_ID);
			pw_en   = (cmd.wr != JN_NONE) && (jy < DEPTH_ID);
			nw_addr = jx[AW-1:0];
			pw_addr = jy[AW-1:0];
			nw_data = jy;
			pw_data = jx;
		end
	end

	always_ff @(posedge clk) begin
		if (nw_en) begin
			next_link_q[nw_addr] <= nw_data;
		end
		if (pw_en) begin
			prev_link_q[pw_addr] <= pw_data;
		end
		if (nr_en && (nr_id < DEPTH_ID)) begin
			rd_next_q <= next_link_q[nr_id[AW-1:0]];
		end
		if (pr_en && (pr_id < DEPTH_ID)) begin
			rd_prev_q <= prev_link_q[pr_id[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
			first_node_q <= FIRST_NODE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_NODE_COUNT: node_count_q <= cfg_data;
				CFG_FIRST_NODE: first_node_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Operation operands and walk bookkeeping.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q       <= item.node_a;
			b_q       <= item.node_b;
			c_q       <= item.node_c;
			n_q       <= n_new;
			f_q       <= f_new;
			clr_idx_q <= '0;
			first_q   <= 1'b1;
			cnt_q     <= item.node_b;
			k_q       <= '0;
		end
		if (cmd.wr == JN_CLEAR) begin
			clr_idx_q <= clr_idx_q + AW'(1);
		end
		if (cmd.walk_count) begin
			// The first step still sees the neighbor read of the start node.
			if (first_q) begin
				other_q <= back ? rd_next_q : rd_prev_q;
			end
			if (status.cur_ok) begin
				k_q     <= k_q + KW'(1);
				cnt_q   <= cnt_q - CNT_W'(1);
				first_q <= 1'b0;
			end else begin
				end_q <= cur;
			end
		end
		if (cmd.sum_update) begin
			first_q <= 1'b1;
			j_q     <= '0;
		end
		if (cmd.walk_emit) begin
			j_q     <= j_q + KW'(1);
			first_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (cmd.sum_clear) begin
			sum_q <= '0;
		end else if (cmd.sum_update) begin
			sum_q <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_emit) begin
			res_q.removed_node    <= cur;
			res_q.node_valid      <= 1'b1;
			res_q.shortfall_total <= sum_q;
			res_q.last            <= j_last;
		end else if (cmd.emit_empty) begin
			res_q.removed_node    <= '0;
			res_q.node_valid      <= 1'b0;
			res_q.shortfall_total <= sum_q;
			res_q.last            <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.walk_emit || cmd.emit_empty) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

endmodule

[src/linked_line_editor.sv]
// Linked line editor: a line of node ids kept as a doubly linked list in two link tables.
// Restart makes a clearing pass over all MAX_NODES + 3 table entries. Remove runs one walk
// to count, one walk to emit at one node per cycle while the result is not stalled, then
// the closing join.
// One item is worked on at a time. Reset clears control state, the shortfall sum and
// the configuration to node_count 64 and first_node 1; link tables are set by restart.
module linked_line_editor
	import lle_pkg::*;
#(
	parameter int MAX_NODES = LLE_MAX_NODES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  item_t                item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ID_W-1:0]      cfg_data
);

	cmd_t    cmd;
	status_t status;

	// Configuration transactions complete in the cycle they are offered.
	assign cfg_ready = 1'b1;

	lle_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.operation  (item.operation),
		.item_stall (item_stall),
		.status     (status),
		.cmd        (cmd)
	);

	lle_datapath #(
		.MAX_NODES (MAX_NODES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_stall (result_stall),
		.cmd          (cmd),
		.status       (status),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule

[test/line_check_pkg.sv]
// Scoreboard for the linked line editor testbench: keeps its own copy of the link tables,
// the shortfall total and both registers, and queues the removals each edit must produce.
// Depends on lle_pkg for the payload structs, operation codes and register indexes.
package line_check_pkg;
	import lle_pkg::*;

	localparam int LINK_DEPTH = LLE_MAX_NODES + 3;

	class edit_tracker;
		logic [ID_W-1:0]  next_tab [LINK_DEPTH];
		logic [ID_W-1:0]  prev_tab [LINK_DEPTH];
		bit               in_line [LINK_DEPTH];
		logic [SUM_W-1:0] shortfall;
		logic [ID_W-1:0]  count_reg;
		logic [ID_W-1:0]  first_reg;
		result_t          pending_removals [$];
		int               fails;

		function new();
			count_reg = NODE_COUNT_RST;
			first_reg = FIRST_NODE_RST;
			shortfall = '0;
			fails = 0;
			foreach (next_tab[i]) begin
				next_tab[i] = '0;
				prev_tab[i] = '0;
				in_line[i] = 1'b0;
			end
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [ID_W-1:0] val);
			if (idx == CFG_NODE_COUNT) begin
				count_reg = val;
			end else begin
				first_reg = val;
			end
		endfunction

		// Node count as the block uses it, held to 1..MAX_NODES.
		function int unsigned span();
			if (count_reg < 1) return 1;
			if (count_reg > LLE_MAX_NODES) return LLE_MAX_NODES;
			return count_reg;
		endfunction

		function bit is_real(int unsigned x);
			return x >= 1 && x <= span();
		endfunction

		function int unsigned next_of(int unsigned x);
			return x < LINK_DEPTH ? next_tab[x] : 0;
		endfunction

		function int unsigned prev_of(int unsigned x);
			return x < LINK_DEPTH ? prev_tab[x] : 0;
		endfunction

		function void link(int unsigned x, int unsigned y);
			if (x < LINK_DEPTH) next_tab[x] = ID_W'(y);
			if (y < LINK_DEPTH) prev_tab[y] = ID_W'(x);
		endfunction

		function void apply_edit(item_t it);
			int unsigned n, a, b, c, f, left, lo, hi;
			int unsigned taken [$];
			result_t r;
			n = span();
			a = it.node_a;
			b = it.node_b;
			c = it.node_c;
			case (it.operation)
				OP_RESTART: begin
					f = first_reg;
					if (f < 1) f = 1;
					if (f > n) f = n;
					foreach (next_tab[i]) begin
						next_tab[i] = '0;
						prev_tab[i] = '0;
						in_line[i] = 1'b0;
					end
					link(n + 1, f);
					link(f, n + 2);
					in_line[f] = 1'b1;
					shortfall = '0;
				end
				OP_INSERT: begin
					if (is_real(a) && is_real(b)) begin
						if (c == DIR_BACK) begin
							link(prev_of(b), a);
							link(a, b);
						end else begin
							link(a, next_of(b));
							link(b, a);
						end
						in_line[a] = 1'b1;
					end
				end
				OP_MOVE: begin
					// The three joins run in a fixed order, even when c lies in the segment.
					if (is_real(a) && is_real(b) && is_real(c)) begin
						link(prev_of(a), next_of(b));
						link(prev_of(c), a);
						link(b, c);
					end
				end
				default: begin
					left = b;
					if (c == DIR_BACK) begin
						lo = a;
						hi = next_of(a);
						while (is_real(lo) && left != 0 && taken.size() < LLE_MAX_NODES) begin
							taken = {taken, lo};
							lo = prev_of(lo);
							left--;
						end
					end else begin
						hi = a;
						lo = prev_of(a);
						while (is_real(hi) && left != 0 && taken.size() < LLE_MAX_NODES) begin
							taken = {taken, hi};
							hi = next_of(hi);
							left--;
						end
					end
					if (taken.size() != 0) link(lo, hi);
					if (~shortfall < left) begin
						shortfall = '1;
					end else begin
						shortfall += left;
					end
					r.shortfall_total = shortfall;
					if (taken.size() == 0) begin
						r.removed_node = '0;
						r.node_valid = 1'b0;
						r.last = 1'b1;
						pending_removals = {pending_removals, r};
					end
					foreach (taken[i]) begin
						r.removed_node = ID_W'(taken[i]);
						r.node_valid = 1'b1;
						r.last = (i == taken.size() - 1);
						in_line[taken[i]] = 1'b0;
						pending_removals = {pending_removals, r};
					end
				end
			endcase
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				fails++;
			end
		endfunction

		function void check_removal(result_t got);
			result_t want;
			if (pending_removals.size() == 0) begin
				$error("result with nothing expected: removed_node %0d, shortfall_total %0d",
					got.removed_node, got.shortfall_total);
				fails++;
				return;
			end
			want = pending_removals.pop_front();
			compare_field("removed_node", want.removed_node, got.removed_node);
			compare_field("node_valid", want.node_valid, got.node_valid);
			compare_field("shortfall_total", want.shortfall_total, got.shortfall_total);
			compare_field("last", want.last, got.last);
		endfunction

		function int pending();
			return pending_removals.size();
		endfunction
	endclass

endpackage

[test/tb.sv]
// Top-level testbench for linked_line_editor: directed edits, then random edit sequences
// under several register settings and idle/stall mixes, checked against edit_tracker.
// Depends on lle_pkg, line_check_pkg and the linked_line_editor RTL.
module tb;
	import lle_pkg::*;
	import line_check_pkg::*;

	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int RANDOM_PER_SETTING = 42;
	localparam int SETTINGS_RUN = 8;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_stall;
	item_t                item = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	result_t              result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ID_W-1:0]      cfg_data = '0;

	int unsigned send_gap_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned cycle_cnt = 0;

	// Register settings per phase; out-of-range values check the clamping.
	logic [ID_W-1:0] set_count [SETTINGS_RUN] = '{7'd64, 7'd1, 7'd5, 7'd127, 7'd0, 7'd12, 7'd33, 7'd64};
	logic [ID_W-1:0] set_first [SETTINGS_RUN] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd3, 7'd100, 7'd17, 7'd1};
	int unsigned gap_mix [4] = '{0, 74, 0, 11};
	int unsigned stall_mix [4] = '{0, 0, 74, 11};

	edit_tracker tracker;

	linked_line_editor dut (
		.clk,
		.arst_n,
		.item_valid,
		.item_stall,
		.item,
		.result_valid,
		.result_stall,
		.result,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	always @(negedge clk) result_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) tracker.check_removal(result);
	end

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	function automatic item_t edit(logic [OP_W-1:0] op, logic [ID_W-1:0] a,
		logic [CNT_W-1:0] b, logic [ID_W-1:0] c);
		item_t it;
		it.operation = op;
		it.node_a = a;
		it.node_b = b;
		it.node_c = c;
		return it;
	endfunction

	// Picks a node that is in the line (or not), falling back to any real id.
	function automatic logic [ID_W-1:0] pick_node(bit linked);
		int unsigned n;
		int unsigned pool [$];
		n = tracker.span();
		for (int unsigned i = 1; i <= n; i++) begin
			if (tracker.in_line[i] == linked) pool = {pool, i};
		end
		if (pool.size() == 0) return ID_W'($urandom_range(1, n));
		return ID_W'(pool[$urandom_range(pool.size() - 1)]);
	endfunction

	// Mostly well-formed edits on the current line, with restarts and raw noise mixed in.
	function automatic item_t next_edit();
		item_t it;
		int unsigned pick, steps, x;
		it = item_t'($urandom);
		pick = $urandom_range(99);
		if (pick < 40) begin
			it.operation = OP_INSERT;
			it.node_a = pick_node(1'b0);
			it.node_b = CNT_W'(pick_node(1'b1));
			it.node_c = $urandom_range(1) ? DIR_BACK : ID_W'($urandom);
		end else if (pick < 60) begin
			it.operation = OP_MOVE;
			it.node_a = pick_node(1'b1);
			x = it.node_a;
			steps = $urandom_range(3);
			for (int k = 0; k < steps && tracker.is_real(tracker.next_of(x)); k++) begin
				x = tracker.next_of(x);
			end
			it.node_b = CNT_W'(x);
			it.node_c = pick_node(1'b1);
		end else if (pick < 87) begin
			it.operation = OP_REMOVE;
			it.node_a = pick_node(1'b1);
			it.node_b = ($urandom_range(9) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(6));
			it.node_c = $urandom_range(1) ? DIR_BACK : ID_W'($urandom);
		end else if (pick < 91) begin
			it.operation = OP_RESTART;
		end
		return it;
	endfunction

	task automatic send_edit(input item_t it);
		@(negedge clk);
		while ($urandom_range(99) < send_gap_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		tracker.apply_edit(it);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ID_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_register(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Restart and link edits give no result, so wait out the longest operation as well.
	task automatic settle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		tracker = new();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Directed edits with the reset settings: 64 nodes, line starting at node 1.
		send_edit(edit(OP_RESTART, 7'd0, 16'd0, 7'd0));
		send_edit(edit(OP_INSERT, 7'd2, 16'd1, 7'd0));
		send_edit(edit(OP_INSERT, 7'd3, 16'd1, DIR_BACK));
		send_edit(edit(OP_INSERT, 7'd64, 16'd2, 7'd127));
		send_edit(edit(OP_INSERT, 7'd0, 16'd1, 7'd0));
		send_edit(edit(OP_INSERT, 7'd65, 16'hFFFF, DIR_BACK));
		send_edit(edit(OP_MOVE, 7'd1, 16'd2, 7'd3));
		send_edit(edit(OP_MOVE, 7'd1, 16'd2, 7'd0));
		send_edit(edit(OP_MOVE, 7'd127, 16'd2, 7'd3));
		send_edit(edit(OP_REMOVE, 7'd2, 16'd2, 7'd0));
		// Backward walk runs into the head sentinel before the count is used up.
		send_edit(edit(OP_REMOVE, 7'd64, 16'd5, DIR_BACK));
		send_edit(edit(OP_REMOVE, 7'd0, 16'd4, 7'd0));
		send_edit(edit(OP_REMOVE, 7'd127, 16'hFFFF, DIR_BACK));
		send_edit(edit(OP_RESTART, 7'd0, 16'd0, 7'd0));
		send_edit(edit(OP_REMOVE, 7'd1, 16'd0, 7'd0));
		send_edit(edit(OP_REMOVE, 7'd1, 16'd1, DIR_BACK));
		send_edit(edit(OP_RESTART, 7'd0, 16'd0, 7'd0));
		send_edit(edit(OP_INSERT, 7'd5, 16'd1, 7'd0));
		send_edit(edit(OP_INSERT, 7'd9, 16'd5, 7'd0));
		// Target node sits inside the moved segment.
		send_edit(edit(OP_MOVE, 7'd1, 16'd5, 7'd5));
		send_edit(edit(OP_REMOVE, 7'd9, 16'd20, DIR_BACK));
		send_edit(edit(OP_RESTART, 7'd0, 16'd0, 7'd0));
		// Inserting a node after itself makes a loop, so the walk stops at the removal cap.
		send_edit(edit(OP_INSERT, 7'd1, 16'd1, 7'd0));
		send_edit(edit(OP_REMOVE, 7'd1, 16'd100, 7'd0));
		send_edit(edit(OP_REMOVE, 7'd1, 16'hFFFF, 7'd64));
		settle();

		for (int s = 0; s < SETTINGS_RUN; s++) begin
			send_gap_pct = gap_mix[(s + 1) % 4];
			stall_pct = stall_mix[(s + 1) % 4];
			write_reg(CFG_NODE_COUNT, set_count[s]);
			write_reg(CFG_FIRST_NODE, set_first[s]);
			send_edit(edit(OP_RESTART, 7'd0, 16'd0, 7'd0));
			repeat (RANDOM_PER_SETTING) send_edit(next_edit());
			settle();
		end

		if (tracker.fails == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[linked_line_editor.f]
src/lle_pkg.sv
src/lle_ctrl.sv
src/lle_datapath.sv
src/linked_line_editor.sv
test/line_check_pkg.sv
test/tb.sv
